>>> sv/rcna_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcna_pkg
// Shared types and constants of the reference-counted node table allocator.
// ----------------------------------------------------------------------------
package rcna_pkg;

    localparam int NODES_DEF = 1024;

    localparam int IDX_W  = 10;
    localparam int CNT_W  = 16;
    localparam int SIZE_W = 31;
    localparam int LINK_W = 31;
    localparam int NODE_W = CNT_W + SIZE_W + LINK_W;
    localparam int MODE_W = 3;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 2;

    // busy map: one bit per node, count != 0
    localparam int MAP_W  = 32;
    localparam int MAP_BW = 5;
    localparam int MAP_WORDS_DEF = (NODES_DEF + MAP_W - 1) / MAP_W;
    localparam int MAP_WAW_DEF   = (MAP_WORDS_DEF > 1) ? $clog2(MAP_WORDS_DEF) : 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 3'd0,
        MODE_DEC   = 3'd1,
        MODE_READ  = 3'd2,
        MODE_WRITE = 3'd3,
        MODE_SIZE  = 3'd4
    } t_mode;

    typedef struct packed {
        logic              found;
        logic [MAP_BW-1:0] pos;
    } t_map_hit;

endpackage : rcna_pkg
`default_nettype wire

>>> sv/rcna_freemap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcna_freemap
// Busy-bit map memory, one 32-bit word per row, with a registered read port
// and a search for the lowest free bit at or above a start position in the word read.
// ----------------------------------------------------------------------------
module rcna_freemap #(
    parameter int NWORDS = rcna_pkg::MAP_WORDS_DEF,
    parameter int WAW    = rcna_pkg::MAP_WAW_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rd_en,
    input  wire  [WAW-1:0]               i_rd_word,
    input  wire                          i_wr_en,
    input  wire  [WAW-1:0]               i_wr_word,
    input  wire  [rcna_pkg::MAP_W-1:0]   i_wr_data,
    input  wire  [rcna_pkg::MAP_BW-1:0]  i_from_pos,
    output logic [rcna_pkg::MAP_W-1:0]   o_rd_data,
    output rcna_pkg::t_map_hit           o_hit
);
    import rcna_pkg::*;

    logic [MAP_W-1:0] r_map [NWORDS];
    logic [MAP_W-1:0] r_rd;
    logic [MAP_W-1:0] w_low;
    logic [MAP_W-1:0] w_masked;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_map[i_wr_word] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_map[i_rd_word];
        end
    end

    assign o_rd_data = r_rd;
    assign w_low     = (MAP_W'(1) << i_from_pos) - MAP_W'(1);
    assign w_masked  = r_rd | w_low;

    always_comb begin
        o_hit.found = 1'b0;
        o_hit.pos   = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (!w_masked[i]) begin
                o_hit.found = 1'b1;
                o_hit.pos   = MAP_BW'(i);
            end
        end
    end

endmodule : rcna_freemap
`default_nettype wire

>>> sv/refcounted_node_table_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_node_table_allocator_core
// Node table with reference counts, sizes and links in one memory and a busy
// bit map in a second; first-fit allocation by scanning the map word by word.
// ----------------------------------------------------------------------------
// Result: registered from S_EXEC, which modifies the node row read at acceptance; a held
//   result stalls execute. In range, decrement, write and set size write the row back;
//   tready is only high in S_IDLE, so a new command waits until the last one is done.
//   Allocate claims the free-pointer node, then scans the 32-node map words for the next
//   free node, unless the table is full or the top node is claimed. Reset: a clearing
//   pass zeroes both memories; no input transaction is accepted until it ends.
module refcounted_node_table_allocator_core #(
    parameter int NODES = rcna_pkg::NODES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // node_index[9:0], count_in[25:10], size_in[56:26], link_in[87:57]
    input  wire  [rcna_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // mode[2:0]
    input  wire  [rcna_pkg::MODE_W-1:0]      i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // node_out[9:0], count_out[25:10], size_out[56:26], link_out[87:57]
    output logic [rcna_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // deleted[0], status[1]
    output logic [rcna_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);
    import rcna_pkg::*;

    localparam int AW     = $clog2(NODES);
    localparam int FW     = $clog2(NODES + 1);
    localparam int IW     = (AW > IDX_W) ? AW : IDX_W;
    localparam int NWORDS = (NODES + MAP_W - 1) / MAP_W;
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PW     = WAW + MAP_BW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SREQ,
        S_SCHK
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_clr;
    logic [FW-1:0]       r_free;
    logic [MODE_W-1:0]   r_mode;
    logic [IDX_W-1:0]    r_idx;
    logic [AW-1:0]       r_addr;
    logic                r_inrange;
    logic                r_full;
    logic [CNT_W-1:0]    r_cnt_in;
    logic [SIZE_W-1:0]   r_size_in;
    logic [LINK_W-1:0]   r_link_in;
    logic [PW-1:0]       r_pos;

    logic [NODE_W-1:0]   r_node_mem [NODES];
    logic [NODE_W-1:0]   r_node_rd;

    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_node;
    logic [CNT_W-1:0]    r_out_cnt;
    logic [SIZE_W-1:0]   r_out_size;
    logic [LINK_W-1:0]   r_out_link;
    logic                r_out_del;
    logic                r_out_st;

    // input unpack
    logic [MODE_W-1:0]   w_in_mode;
    logic [IDX_W-1:0]    w_in_idx;
    logic [CNT_W-1:0]    w_in_cnt;
    logic [SIZE_W-1:0]   w_in_size;
    logic [LINK_W-1:0]   w_in_link;

    logic                w_accept;
    logic                w_full;
    logic                w_in_inrange;
    logic                w_in_alloc;
    logic [IW-1:0]       w_idx_x;
    logic [AW-1:0]       w_acc_addr;
    logic                w_acc_rd;
    logic [PW-1:0]       w_acc_pos;
    logic [PW-1:0]       w_cur_pos;
    logic [IW-1:0]       w_addr_x;
    logic                w_out_free;

    // modify stage
    logic [CNT_W-1:0]    w_old_cnt;
    logic [SIZE_W-1:0]   w_old_size;
    logic [LINK_W-1:0]   w_old_link;
    logic [CNT_W-1:0]    w_new_cnt;
    logic [SIZE_W-1:0]   w_new_size;
    logic [LINK_W-1:0]   w_new_link;
    logic                w_node_wr;
    logic                w_bit_wr;
    logic                w_bit_val;
    logic                w_lower;
    logic [IDX_W-1:0]    w_res_node;
    logic                w_res_zero;
    logic                w_res_del;
    logic                w_res_st;
    logic [MAP_W-1:0]    w_map_mod;

    // scan
    logic [PW:0]         w_nxt;
    logic [WAW-1:0]      w_pos_word;
    logic                w_last_word;
    logic [PW-1:0]       w_cand;

    // memory ports
    logic                w_node_we;
    logic [AW-1:0]       w_node_waddr;
    logic [NODE_W-1:0]   w_node_wdata;
    logic                w_map_re;
    logic [WAW-1:0]      w_map_rword;
    logic                w_map_we;
    logic [WAW-1:0]      w_map_wword;
    logic [MAP_W-1:0]    w_map_wdata;
    logic [MAP_W-1:0]    w_map_rd;
    t_map_hit            w_hit;

    assign w_in_mode = i_s_axis_tuser;
    assign w_in_idx  = i_s_axis_tdata[IDX_W-1:0];
    assign w_in_cnt  = i_s_axis_tdata[IDX_W +: CNT_W];
    assign w_in_size = i_s_axis_tdata[IDX_W+CNT_W +: SIZE_W];
    assign w_in_link = i_s_axis_tdata[IDX_W+CNT_W+SIZE_W +: LINK_W];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_free == FW'(NODES));
    assign w_in_inrange    = (32'(w_in_idx) < 32'(NODES));
    assign w_in_alloc      = (w_in_mode == MODE_ALLOC);
    assign w_idx_x         = IW'(w_in_idx);
    assign w_acc_addr      = w_in_alloc ? (w_full ? '0 : r_free[AW-1:0]) : w_idx_x[AW-1:0];
    assign w_acc_rd        = w_accept && (w_in_alloc ? !w_full : w_in_inrange);
    assign w_acc_pos       = PW'(w_acc_addr);
    assign w_cur_pos       = PW'(r_addr);
    assign w_addr_x        = IW'(r_addr);
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_old_cnt  = r_node_rd[SIZE_W+LINK_W +: CNT_W];
    assign w_old_size = r_node_rd[LINK_W +: SIZE_W];
    assign w_old_link = r_node_rd[LINK_W-1:0];

    always_comb begin
        w_new_cnt  = w_old_cnt;
        w_new_size = w_old_size;
        w_new_link = w_old_link;
        w_node_wr  = 1'b0;
        w_bit_wr   = 1'b0;
        w_bit_val  = 1'b0;
        w_lower    = 1'b0;
        w_res_node = r_idx;
        w_res_zero = 1'b0;
        w_res_del  = 1'b0;
        w_res_st   = 1'b0;
        if (r_mode == MODE_ALLOC) begin
            if (r_full) begin
                w_res_node = '0;
                w_res_zero = 1'b1;
                w_res_st   = 1'b1;
            end else begin
                w_new_cnt  = CNT_W'(1);
                w_new_size = '0;
                w_new_link = '0;
                w_node_wr  = 1'b1;
                w_bit_wr   = 1'b1;
                w_bit_val  = 1'b1;
                w_res_node = w_addr_x[IDX_W-1:0];
            end
        end else if (!r_inrange) begin
            w_res_zero = 1'b1;
        end else begin
            unique case (r_mode)
                MODE_DEC: begin
                    w_node_wr = 1'b1;
                    if (w_old_cnt <= CNT_W'(1)) begin
                        w_new_cnt  = '0;
                        w_new_size = '0;
                        w_new_link = '0;
                        w_bit_wr   = 1'b1;
                        w_bit_val  = 1'b0;
                        w_res_del  = 1'b1;
                        w_lower    = (32'(r_addr) < 32'(r_free));
                    end else begin
                        w_new_cnt = w_old_cnt - CNT_W'(1);
                    end
                end
                MODE_WRITE: begin
                    w_new_cnt  = r_cnt_in;
                    w_new_size = r_size_in;
                    w_new_link = r_link_in;
                    w_node_wr  = 1'b1;
                    w_bit_wr   = 1'b1;
                    w_bit_val  = |r_cnt_in;
                end
                MODE_SIZE: begin
                    w_new_size = r_size_in;
                    w_node_wr  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_map_mod = w_map_rd;
        w_map_mod[w_cur_pos[MAP_BW-1:0]] = w_bit_val;
    end

    assign w_nxt       = (PW + 1)'(r_addr) + (PW + 1)'(1);
    assign w_pos_word  = r_pos[PW-1:MAP_BW];
    assign w_last_word = (w_pos_word == WAW'(NWORDS - 1));
    assign w_cand      = {w_pos_word, w_hit.pos};

    // memory port selection
    always_comb begin
        w_node_we    = 1'b0;
        w_node_waddr = r_addr;
        w_node_wdata = {w_new_cnt, w_new_size, w_new_link};
        w_map_we     = 1'b0;
        w_map_wword  = w_cur_pos[PW-1:MAP_BW];
        w_map_wdata  = w_map_mod;
        if (r_state == S_CLEAR) begin
            w_node_we    = 1'b1;
            w_node_waddr = r_clr;
            w_node_wdata = '0;
            w_map_we     = (32'(r_clr) < 32'(NWORDS));
            w_map_wword  = WAW'(r_clr);
            w_map_wdata  = '0;
        end else if (r_state == S_EXEC) begin
            w_node_we = w_node_wr;
            w_map_we  = w_bit_wr;
        end
    end

    always_comb begin
        w_map_re    = 1'b0;
        w_map_rword = w_acc_pos[PW-1:MAP_BW];
        priority if (r_state == S_IDLE) begin
            w_map_re = w_acc_rd;
        end else if (r_state == S_SREQ) begin
            w_map_re    = 1'b1;
            w_map_rword = w_pos_word;
        end else if (r_state == S_SCHK) begin
            w_map_re    = !w_hit.found && !w_last_word;
            w_map_rword = w_pos_word + WAW'(1);
        end else begin
            w_map_re = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_waddr] <= w_node_wdata;
        end
        if (w_acc_rd) begin
            r_node_rd <= r_node_mem[w_acc_addr];
        end
    end

    rcna_freemap #(
        .NWORDS (NWORDS),
        .WAW    (WAW)
    ) u_freemap (
        .i_clk      (i_clk),
        .i_rd_en    (w_map_re),
        .i_rd_word  (w_map_rword),
        .i_wr_en    (w_map_we),
        .i_wr_word  (w_map_wword),
        .i_wr_data  (w_map_wdata),
        .i_from_pos (r_pos[MAP_BW-1:0]),
        .o_rd_data  (w_map_rd),
        .o_hit      (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && r_state != S_EXEC) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode    <= w_in_mode;
                        r_idx     <= w_in_idx;
                        r_addr    <= w_acc_addr;
                        r_inrange <= w_in_inrange;
                        r_full    <= w_full;
                        r_cnt_in  <= w_in_cnt;
                        r_size_in <= w_in_size;
                        r_link_in <= w_in_link;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_lower) begin
                        r_free <= FW'(r_addr);
                    end
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_node  <= w_res_node;
                        r_out_cnt   <= w_res_zero ? '0 : w_new_cnt;
                        r_out_size  <= w_res_zero ? '0 : w_new_size;
                        r_out_link  <= w_res_zero ? '0 : w_new_link;
                        r_out_del   <= w_res_del;
                        r_out_st    <= w_res_st;
                        if (r_mode == MODE_ALLOC && !r_full) begin
                            if (32'(w_nxt) >= 32'(NODES)) begin
                                r_free  <= FW'(NODES);
                                r_state <= S_IDLE;
                            end else begin
                                r_pos   <= w_nxt[PW-1:0];
                                r_state <= S_SREQ;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SREQ: begin
                    r_state <= S_SCHK;
                end
                S_SCHK: begin
                    if (w_hit.found) begin
                        r_free  <= (32'(w_cand) >= 32'(NODES)) ? FW'(NODES) : FW'(w_cand);
                        r_state <= S_IDLE;
                    end else if (w_last_word) begin
                        r_free  <= FW'(NODES);
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= {w_pos_word + WAW'(1), MAP_BW'(0)};
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_link, r_out_size, r_out_cnt, r_out_node};
    assign o_m_axis_tuser  = {r_out_st, r_out_del};

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= 32'(NODES))
        else $error("free pointer beyond table");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == S_EXEC))
        else $error("accepted command not executed");

    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SREQ) |-> ($past(r_state) == S_EXEC && $past(r_mode) == MODE_ALLOC))
        else $error("scan started without allocate");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_del && r_out_st))
        else $error("deleted and full flagged together");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");

endmodule : refcounted_node_table_allocator_core
`default_nettype wire

>>> bench/refcounted_node_table_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_node_table_allocator_core_tb
// Self-checking bench for the node table allocator. It drives command
// transactions on the input stream and keeps its own copy of the node table
// and the free pointer. From that copy it predicts every result transaction
// and compares each one field by field. Directed corner cases come first,
// then random churn and a fill up to a full table under random gaps and
// stalls on both sides, then a long output hold-off and a release-heavy churn.
// ----------------------------------------------------------------------------
module refcounted_node_table_allocator_core_tb;
    import rcna_pkg::*;

    localparam int NODES       = NODES_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 5000;

    typedef struct packed {
        logic [IDX_W-1:0]  node;
        logic [CNT_W-1:0]  count;
        logic [SIZE_W-1:0] size;
        logic [LINK_W-1:0] link;
        logic              deleted;
        logic              status;
    } t_node_view;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic [MODE_W-1:0]     s_mode  = '0;
    logic                  m_ready = 1'b0;
    wire                   s_ready;
    wire                   m_valid;
    wire  [OUT_DATA_W-1:0] m_data;
    wire  [OUT_USER_W-1:0] m_user;

    logic [CNT_W-1:0]  tbl_count [NODES];
    logic [SIZE_W-1:0] tbl_size  [NODES];
    logic [LINK_W-1:0] tbl_link  [NODES];
    int unsigned       first_free;
    int unsigned       busy_top;

    t_node_view  pending_results[$];
    int          errors;
    int          n_cmds;
    int          n_allocs;
    int          n_full;
    int          n_frees;
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    bit          hold_request;

    refcounted_node_table_allocator_core #(
        .NODES(NODES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_mode),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_node_view node_view(int unsigned n, logic del);
        t_node_view v;
        v.node    = IDX_W'(n);
        v.count   = tbl_count[n];
        v.size    = tbl_size[n];
        v.link    = tbl_link[n];
        v.deleted = del;
        v.status  = 1'b0;
        return v;
    endfunction

    // Applies one command to the local table copy and returns the result it gives.
    function automatic t_node_view table_apply(logic [MODE_W-1:0] mode,
            logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt,
            logic [SIZE_W-1:0] sz, logic [LINK_W-1:0] lnk);
        t_node_view  v;
        logic        freed;
        int unsigned k;
        v     = '0;
        freed = 1'b0;
        n_cmds++;
        if (mode == MODE_ALLOC) begin
            n_allocs++;
            if (first_free >= NODES) begin
                n_full++;
                v.status = 1'b1;
            end else begin
                k            = first_free;
                tbl_count[k] = 1;
                tbl_size[k]  = '0;
                tbl_link[k]  = '0;
                v            = node_view(k, 1'b0);
                if (k + 1 > busy_top)
                    busy_top = k + 1;
                k++;
                while (k < NODES && tbl_count[k] != 0)
                    k++;
                first_free = k;
            end
        end else begin
            case (mode)
                MODE_DEC: begin
                    if (tbl_count[idx] <= 1) begin
                        tbl_count[idx] = '0;
                        tbl_size[idx]  = '0;
                        tbl_link[idx]  = '0;
                        if (idx < first_free)
                            first_free = idx;
                        freed = 1'b1;
                        n_frees++;
                    end else begin
                        tbl_count[idx] = tbl_count[idx] - 1'b1;
                    end
                end
                MODE_WRITE: begin
                    tbl_count[idx] = cnt;
                    tbl_size[idx]  = sz;
                    tbl_link[idx]  = lnk;
                    if (cnt != 0 && idx >= busy_top)
                        busy_top = idx + 1;
                end
                MODE_SIZE: begin
                    tbl_size[idx] = sz;
                end
                default: ;
            endcase
            v = node_view(idx, freed);
        end
        return v;
    endfunction

    // Sends one command transaction; the prediction is taken at acceptance.
    task automatic issue_cmd(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
            input logic [CNT_W-1:0] cnt, input logic [SIZE_W-1:0] sz,
            input logic [LINK_W-1:0] lnk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_data  <= {lnk, sz, cnt, idx};
        do @(posedge i_clk); while (!s_ready);
        pending_results.push_back(table_apply(mode, idx, cnt, sz, lnk));
        @(negedge i_clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_node();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return $urandom_range(1) ? '1 : '0;
        if (r <= 2 || busy_top == 0)
            return IDX_W'($urandom);
        if (r == 3 && first_free < NODES)
            return IDX_W'(first_free);
        return IDX_W'($urandom_range(busy_top - 1));
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 7)
            return CNT_W'($urandom_range(3));
        if (r < 9)
            return CNT_W'($urandom);
        return '1;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return SIZE_W'($urandom);
    endfunction

    task automatic issue_random_cmd(input int unsigned alloc_pct, input int unsigned dec_pct);
        int unsigned      r;
        logic [MODE_W-1:0] mode;
        r = $urandom_range(99);
        if (r < alloc_pct)
            mode = MODE_ALLOC;
        else if (r < alloc_pct + dec_pct)
            mode = MODE_DEC;
        else begin
            case ($urandom_range(2))
                0:       mode = MODE_READ;
                1:       mode = MODE_WRITE;
                default: mode = MODE_SIZE;
            endcase
        end
        issue_cmd(mode, pick_node(), pick_count(), pick_word(), pick_word());
    endtask

    task automatic test_basic_ops();
        issue_cmd(MODE_ALLOC, 10'd0, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_ALLOC, 10'd0, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_READ, 10'd0, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_WRITE, 10'd1, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        issue_cmd(MODE_SIZE, 10'd0, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        issue_cmd(MODE_DEC, 10'd1, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_READ, 10'd1023, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_WRITE, 10'd1023, 16'd1, 31'h2AAA_AAAA, 31'h5555_5555);
        issue_cmd(MODE_DEC, 10'd1023, 16'd0, 31'd0, 31'd0);
        // free node with count already zero, above the free pointer
        issue_cmd(MODE_DEC, 10'd5, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_DEC, 10'd0, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_ALLOC, 10'd0, 16'd0, 31'd0, 31'd0);
    endtask

    task automatic test_stale_free_head();
        // give a count to the node at the free pointer, then allocate over it
        issue_cmd(MODE_WRITE, IDX_W'(first_free), 16'd3, 31'h1234_5678, 31'h0765_4321);
        issue_cmd(MODE_ALLOC, 10'd0, 16'd0, 31'd0, 31'd0);
        // free a node below the pointer behind its back
        issue_cmd(MODE_WRITE, 10'd1, 16'd0, 31'd7, 31'd9);
        issue_cmd(MODE_ALLOC, 10'd0, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_ALLOC, 10'd0, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_READ, 10'd1, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_SIZE, 10'd1023, 16'd0, 31'h5555_5555, 31'd0);
        issue_cmd(MODE_WRITE, 10'd512, 16'h8000, 31'h4000_0000, 31'h4000_0001);
        issue_cmd(MODE_DEC, 10'd512, 16'd0, 31'd0, 31'd0);
    endtask

    task automatic test_random_churn(input int n, input int unsigned alloc_pct,
            input int unsigned dec_pct);
        repeat (n) issue_random_cmd(alloc_pct, dec_pct);
    endtask

    task automatic test_fill_table();
        while (first_free < NODES)
            issue_random_cmd(90, 0);
        repeat (3) issue_cmd(MODE_ALLOC, 10'd0, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_WRITE, 10'd1000, 16'd1, 31'd1, 31'd1);
        issue_cmd(MODE_DEC, 10'd1000, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_ALLOC, 10'd0, 16'd0, 31'd0, 31'd0);
        issue_cmd(MODE_ALLOC, 10'd0, 16'd0, 31'd0, 31'd0);
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (30) issue_random_cmd(20, 20);
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_node_view got;
        t_node_view want;
        if (i_rst_n && m_valid && m_ready) begin
            got.node    = m_data[9:0];
            got.count   = m_data[25:10];
            got.size    = m_data[56:26];
            got.link    = m_data[87:57];
            got.deleted = m_user[0];
            got.status  = m_user[1];
            if (pending_results.size() == 0) begin
                errors++;
                $error("result transaction with no command pending, node_out %0d", got.node);
            end else begin
                want = pending_results.pop_front();
                if (got.node != want.node) begin
                    errors++;
                    $error("node_out: expected %0d, got %0d", want.node, got.node);
                end
                if (got.count != want.count) begin
                    errors++;
                    $error("count_out: expected %0d, got %0d", want.count, got.count);
                end
                if (got.size != want.size) begin
                    errors++;
                    $error("size_out: expected %0d, got %0d", want.size, got.size);
                end
                if (got.link != want.link) begin
                    errors++;
                    $error("link_out: expected %0d, got %0d", want.link, got.link);
                end
                if (got.deleted != want.deleted) begin
                    errors++;
                    $error("deleted: expected %0d, got %0d", want.deleted, got.deleted);
                end
                if (got.status != want.status) begin
                    errors++;
                    $error("status: expected %0d, got %0d", want.status, got.status);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : main_seq
        for (int i = 0; i < NODES; i++) begin
            tbl_count[i] = '0;
            tbl_size[i]  = '0;
            tbl_link[i]  = '0;
        end
        first_free     = 0;
        busy_top       = 0;
        errors         = 0;
        n_cmds         = 0;
        n_allocs       = 0;
        n_full         = 0;
        n_frees        = 0;
        hold_request   = 1'b0;
        send_gap_pct   = 7;
        recv_stall_pct = 48;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_stale_free_head();
        test_random_churn(250, 30, 25);

        send_gap_pct   = 48;
        recv_stall_pct = 7;
        test_fill_table();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_output_backpressure();
        test_random_churn(250, 15, 50);

        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d commands: %0d allocations (%0d on a full table), %0d frees,",
                 n_cmds, n_allocs, n_full, n_frees);
        $display("with input gaps, output stalls and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/rcna_pkg.sv
sv/rcna_freemap.sv
sv/refcounted_node_table_allocator_core.sv
bench/refcounted_node_table_allocator_core_tb.sv
